FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the frame checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define AFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Types, constants and digit decoders of the ASCII frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_EXPECTED_STEP  = 2'd0;
    localparam logic [1:0] REG_CHECKSUM_CHECK = 2'd1;
    localparam logic [1:0] REG_STEP_CHECK     = 2'd2;

    localparam logic [7:0] START_BYTE    = 8'h23;
    localparam logic [6:0] MIN_FRAME_LEN = 7'd7;
    localparam logic [6:0] LEN_CHECK_POS = 7'd6;
    localparam logic [6:0] STEP_FIRST    = 7'd4;
    localparam logic [6:0] STEP_LAST     = 7'd7;

    typedef enum logic [2:0] {
        ST_ACCEPTED      = 3'd0,
        ST_STEP_MISMATCH = 3'd1,
        ST_BAD_START     = 3'd2,
        ST_BAD_LENGTH    = 3'd3,
        ST_BAD_CHECKSUM  = 3'd4
    } status_t;

    typedef struct packed {
        logic [13:0] expected_step;
        logic        checksum_check_enable;
        logic        step_check_enable;
    } cfg_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t dec_digit(input logic [7:0] b);
        digit_t d;
        d.ok  = (b >= 8'h30) && (b <= 8'h39);
        d.val = b[3:0];
        return d;
    endfunction

    function automatic digit_t hex_upper(input logic [7:0] b);
        digit_t d;
        if ((b >= 8'h30) && (b <= 8'h39))
        begin
            d.ok  = 1'b1;
            d.val = b[3:0];
        end
        else if ((b >= 8'h41) && (b <= 8'h46))
        begin
            d.ok  = 1'b1;
            d.val = 4'(b - 8'h37);
        end
        else
        begin
            d.ok  = 1'b0;
            d.val = 4'd0;
        end
        return d;
    endfunction

endpackage

FILE: src/afc_if.sv
// ----------------------------------------------------------------------------
// afc_if
// Valid/ready channels of the frame checker: received bytes and verdicts.
// ----------------------------------------------------------------------------
interface afc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  frame_length;
    logic [13:0] received_step;
    logic [7:0]  computed_sum;

    modport source (output valid, output status, output frame_length,
                    output received_step, output computed_sum, input ready);
    modport sink   (input valid, input status, input frame_length,
                    input received_step, input computed_sum, output ready);
endinterface

FILE: src/afc_apb_regs.sv
// ----------------------------------------------------------------------------
// afc_apb_regs
// APB configuration registers: expected step and the two check enables.
// ----------------------------------------------------------------------------
module afc_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [afc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [afc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [afc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output afc_pkg::cfg_t                   cfg
);

    afc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_step         <= 14'd0;
            cfg_reg.checksum_check_enable <= 1'b1;
            cfg_reg.step_check_enable     <= 1'b1;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                afc_pkg::REG_EXPECTED_STEP:  cfg_reg.expected_step <= pwdata[13:0];
                afc_pkg::REG_CHECKSUM_CHECK: cfg_reg.checksum_check_enable <= pwdata[0];
                afc_pkg::REG_STEP_CHECK:     cfg_reg.step_check_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            afc_pkg::REG_EXPECTED_STEP:  prdata = {18'd0, cfg_reg.expected_step};
            afc_pkg::REG_CHECKSUM_CHECK: prdata = {31'd0, cfg_reg.checksum_check_enable};
            afc_pkg::REG_STEP_CHECK:     prdata = {31'd0, cfg_reg.step_check_enable};
            default:                     prdata = '0;
        endcase
    end

endmodule

FILE: src/afc_frame_engine.sv
// ----------------------------------------------------------------------------
// afc_frame_engine
// Per-byte frame state update and the registered verdict beat.
// ----------------------------------------------------------------------------
module afc_frame_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    output logic               in_take,
    input  afc_pkg::cfg_t      cfg,
    afc_res_if.source          res
);

    logic [6:0]  pos_reg,      pos_next;
    logic [6:0]  len_reg,      len_next;
    logic        len_inv_reg,  len_inv_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [13:0] step_reg,     step_next;
    logic        step_inv_reg, step_inv_next;
    logic        cks_bad_reg,  cks_bad_next;

    logic        res_valid_reg;
    logic [2:0]  status_reg,   status_next;
    logic [6:0]  flen_reg,     flen_next;
    logic [13:0] rstep_reg,    rstep_next;
    logic [7:0]  csum_reg,     csum_next;
    logic        emit;

    logic [6:0]       eff;
    logic [6:0]       len_tens;
    logic [13:0]      stp;
    afc_pkg::digit_t  dd;
    afc_pkg::digit_t  hd;

    assign in_take = in_valid && (!res_valid_reg || res.ready);
    assign dd      = afc_pkg::dec_digit(in_byte);
    assign hd      = afc_pkg::hex_upper(in_byte);
    assign eff     = len_inv_reg ? 7'd0 : len_reg;
    assign len_tens = {dd.val, 3'b000} + {2'b00, dd.val, 1'b0};

    always_comb
    begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        len_inv_next  = len_inv_reg;
        sum_next      = sum_reg;
        step_next     = step_reg;
        step_inv_next = step_inv_reg;
        cks_bad_next  = cks_bad_reg;
        emit          = 1'b0;
        status_next   = afc_pkg::ST_ACCEPTED;
        flen_next     = 7'd0;
        rstep_next    = 14'd0;
        csum_next     = 8'd0;
        stp           = 14'd0;

        if (pos_reg == 7'd0)
        begin
            if (in_byte != afc_pkg::START_BYTE)
            begin
                emit        = 1'b1;
                status_next = afc_pkg::ST_BAD_START;
            end
            else
            begin
                len_next      = 7'd0;
                len_inv_next  = 1'b0;
                step_next     = 14'd0;
                step_inv_next = 1'b0;
                cks_bad_next  = 1'b0;
                sum_next      = in_byte;
                pos_next      = 7'd1;
            end
        end
        else if (pos_reg <= 7'd2)
        begin
            sum_next = sum_reg + in_byte;
            if (!dd.ok)
            begin
                len_inv_next = 1'b1;
                len_next     = 7'd0;
            end
            else if (!len_inv_reg)
            begin
                len_next = (pos_reg == 7'd1) ? len_tens : len_reg + {3'b000, dd.val};
            end
            pos_next = pos_reg + 7'd1;
        end
        else
        begin
            if (({1'b0, pos_reg} + 8'd3) < {1'b0, eff})
            begin
                sum_next = sum_reg + in_byte;
            end

            if ((pos_reg >= afc_pkg::STEP_FIRST) && (pos_reg <= afc_pkg::STEP_LAST))
            begin
                if (!dd.ok)
                begin
                    step_inv_next = 1'b1;
                end
                else if (!step_inv_reg)
                begin
                    step_next = {step_reg[10:0], 3'b000} + {step_reg[12:0], 1'b0}
                              + {10'd0, dd.val};
                end
            end

            if (eff >= afc_pkg::MIN_FRAME_LEN)
            begin
                if (pos_reg == eff - 7'd3)
                begin
                    if (!hd.ok || (hd.val != sum_reg[7:4]))
                    begin
                        cks_bad_next = 1'b1;
                    end
                end
                else if (pos_reg == eff - 7'd2)
                begin
                    if (!hd.ok || (hd.val != sum_reg[3:0]))
                    begin
                        cks_bad_next = 1'b1;
                    end
                end
            end

            if ((pos_reg == afc_pkg::LEN_CHECK_POS) && (eff < afc_pkg::MIN_FRAME_LEN))
            begin
                emit        = 1'b1;
                status_next = afc_pkg::ST_BAD_LENGTH;
                flen_next   = eff;
                pos_next    = 7'd0;
            end
            else if ((eff >= afc_pkg::MIN_FRAME_LEN) && (pos_reg == eff - 7'd1))
            begin
                stp = (step_inv_next || (eff == afc_pkg::MIN_FRAME_LEN)) ? 14'd0 : step_next;
                emit = 1'b1;
                if (cfg.checksum_check_enable && cks_bad_next)
                begin
                    status_next = afc_pkg::ST_BAD_CHECKSUM;
                end
                else if (cfg.step_check_enable && (stp != cfg.expected_step))
                begin
                    status_next = afc_pkg::ST_STEP_MISMATCH;
                end
                flen_next  = eff;
                rstep_next = stp;
                csum_next  = sum_next;
                pos_next   = 7'd0;
            end
            else
            begin
                pos_next = pos_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 7'd0;
            len_reg      <= 7'd0;
            len_inv_reg  <= 1'b0;
            sum_reg      <= 8'd0;
            step_reg     <= 14'd0;
            step_inv_reg <= 1'b0;
            cks_bad_reg  <= 1'b0;
        end
        else if (in_take)
        begin
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            len_inv_reg  <= len_inv_next;
            sum_reg      <= sum_next;
            step_reg     <= step_next;
            step_inv_reg <= step_inv_next;
            cks_bad_reg  <= cks_bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            res_valid_reg <= emit;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && emit)
        begin
            status_reg <= status_next;
            flen_reg   <= flen_next;
            rstep_reg  <= rstep_next;
            csum_reg   <= csum_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = status_reg;
    assign res.frame_length  = flen_reg;
    assign res.received_step = rstep_reg;
    assign res.computed_sum  = csum_reg;

endmodule

FILE: src/ascii_frame_checker.sv
// ----------------------------------------------------------------------------
// ascii_frame_checker
// Checks received ASCII frames ('#', two-digit length, four-digit step, payload,
// two upper-case hex digits of the additive checksum, one end byte) and gives
// one verdict beat per frame, or one per stray byte outside a frame. The block
// takes one byte beat per clock cycle while no verdict is stalled at the output:
// a byte passes the input register, then the frame state and the verdict
// register are updated in the same cycle; a verdict is registered when the
// engine takes the last byte of its frame. The per-byte update of the frame
// state sets this rate. While a verdict waits at the output, the frame state
// holds and at most one more byte is taken into the input register.
// ----------------------------------------------------------------------------
module ascii_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [afc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [afc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [afc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    afc_rx_if.sink                          rx,
    afc_res_if.source                       res
);

    afc_pkg::cfg_t cfg;
    logic          byte_valid_reg;
    logic [7:0]    byte_reg;
    logic          take;

    assign rx.ready = !byte_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            byte_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    afc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afc_frame_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_valid_reg),
        .in_byte  (byte_reg),
        .in_take  (take),
        .cfg      (cfg),
        .res      (res)
    );

endmodule

FILE: src/afc_checker.sv
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks on the verdict beats of the frame checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  status,
    input logic [6:0]  frame_length,
    input logic [13:0] received_step,
    input logic [7:0]  computed_sum
);

    `AFC_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(status) && $stable(frame_length) && $stable(received_step) && $stable(computed_sum), "verdict changed while stalled")
    `AFC_ASSERT_ALWAYS(a_pready, pready, "pready dropped")
    `AFC_ASSERT(a_bad_start, res_valid && status == afc_pkg::ST_BAD_START |-> frame_length == 7'd0 && received_step == 14'd0 && computed_sum == 8'd0, "bad start verdict carries data")
    `AFC_ASSERT(a_bad_len, res_valid && status == afc_pkg::ST_BAD_LENGTH |-> frame_length < afc_pkg::MIN_FRAME_LEN && received_step == 14'd0 && computed_sum == 8'd0, "bad length verdict inconsistent")
    `AFC_ASSERT(a_full_frame, res_valid && (status == afc_pkg::ST_ACCEPTED || status == afc_pkg::ST_STEP_MISMATCH || status == afc_pkg::ST_BAD_CHECKSUM) |-> frame_length >= afc_pkg::MIN_FRAME_LEN, "frame verdict with short length")

endmodule

bind ascii_frame_checker afc_checker u_afc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .status        (res.status),
    .frame_length  (res.frame_length),
    .received_step (res.received_step),
    .computed_sum  (res.computed_sum)
);

FILE: bench/afc_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_verdict_checker
// Watches the byte, verdict and register ports of the frame checker. It keeps
// its own copy of the registers and of the frame state, works out the verdict
// each received byte should give, and compares every verdict beat field by
// field with the oldest verdict still pending.
// ----------------------------------------------------------------------------
module afc_verdict_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [afc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [afc_pkg::APB_DATA_W-1:0] pwdata,
    afc_rx_if                              rx,
    afc_res_if                             res,
    output int                             fail_count,
    output int                             pending
);

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [7:0] HEX_A      = 8'h41;
    localparam logic [7:0] HEX_F      = 8'h46;

    typedef struct packed {
        afc_pkg::status_t status;
        logic [6:0]       frame_length;
        logic [13:0]      received_step;
        logic [7:0]       computed_sum;
    } verdict_t;

    verdict_t    verdict_q[$];

    logic [13:0] cfg_step;
    logic        cfg_sum_en;
    logic        cfg_step_en;

    logic [6:0]  at_byte;
    logic [6:0]  len_val;
    logic        len_bad;
    logic [7:0]  sum_acc;
    logic [13:0] step_acc;
    logic        step_bad;
    logic        sum_bad;

    function automatic void clear_frame_state();
        at_byte  = '0;
        len_val  = '0;
        len_bad  = 1'b0;
        sum_acc  = '0;
        step_acc = '0;
        step_bad = 1'b0;
        sum_bad  = 1'b0;
    endfunction

    function automatic bit take_byte(input logic [7:0] b, output verdict_t v);
        int          p;
        int          eff;
        int          dv;
        bit          dig;
        bit          nib_ok;
        logic [3:0]  nib;
        logic [13:0] stp;
        v   = '0;
        p   = at_byte;
        dig = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
        dv  = int'(b) - int'(DIGIT_ZERO);
        if (p == 0)
        begin
            if (b != afc_pkg::START_BYTE)
            begin
                v.status = afc_pkg::ST_BAD_START;
                return 1'b1;
            end
            clear_frame_state();
            sum_acc = b;
            at_byte = 7'd1;
            return 1'b0;
        end
        if (p <= 2)
        begin
            sum_acc = sum_acc + b;
            if (!dig)
            begin
                len_bad = 1'b1;
                len_val = '0;
            end
            else if (!len_bad)
            begin
                len_val = (p == 1) ? 7'(dv * 10) : 7'(int'(len_val) + dv);
            end
            at_byte = 7'(p + 1);
            return 1'b0;
        end
        eff = len_bad ? 0 : int'(len_val);
        if (p + 3 < eff)
        begin
            sum_acc = sum_acc + b;
        end
        if (p >= int'(afc_pkg::STEP_FIRST) && p <= int'(afc_pkg::STEP_LAST))
        begin
            if (!dig)
            begin
                step_bad = 1'b1;
            end
            else if (!step_bad)
            begin
                step_acc = 14'(int'(step_acc) * 10 + dv);
            end
        end
        if (eff >= int'(afc_pkg::MIN_FRAME_LEN) && (p == eff - 3 || p == eff - 2))
        begin
            nib_ok = 1'b1;
            nib    = '0;
            if (dig)
            begin
                nib = b[3:0];
            end
            else if (b >= HEX_A && b <= HEX_F)
            begin
                nib = 4'(int'(b) - int'(HEX_A) + 10);
            end
            else
            begin
                nib_ok = 1'b0;
            end
            if (!nib_ok || nib != ((p == eff - 3) ? sum_acc[7:4] : sum_acc[3:0]))
            begin
                sum_bad = 1'b1;
            end
        end
        if (p == int'(afc_pkg::LEN_CHECK_POS) && eff < int'(afc_pkg::MIN_FRAME_LEN))
        begin
            v.status       = afc_pkg::ST_BAD_LENGTH;
            v.frame_length = 7'(eff);
            clear_frame_state();
            return 1'b1;
        end
        if (eff >= int'(afc_pkg::MIN_FRAME_LEN) && p == eff - 1)
        begin
            stp = (step_bad || eff == int'(afc_pkg::MIN_FRAME_LEN)) ? '0 : step_acc;
            if (cfg_sum_en && sum_bad)
            begin
                v.status = afc_pkg::ST_BAD_CHECKSUM;
            end
            else if (cfg_step_en && stp != cfg_step)
            begin
                v.status = afc_pkg::ST_STEP_MISMATCH;
            end
            else
            begin
                v.status = afc_pkg::ST_ACCEPTED;
            end
            v.frame_length  = 7'(eff);
            v.received_step = stp;
            v.computed_sum  = sum_acc;
            clear_frame_state();
            return 1'b1;
        end
        at_byte = 7'(p + 1);
        return 1'b0;
    endfunction

    function automatic int check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        verdict_t fresh;
        if (!rst_n)
        begin
            verdict_q.delete();
            clear_frame_state();
            cfg_step    = '0;
            cfg_sum_en  = 1'b1;
            cfg_step_en = 1'b1;
            fail_count  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[afc_pkg::APB_ADDR_W-1:2])
                    afc_pkg::REG_EXPECTED_STEP:  cfg_step    = pwdata[13:0];
                    afc_pkg::REG_CHECKSUM_CHECK: cfg_sum_en  = pwdata[0];
                    afc_pkg::REG_STEP_CHECK:     cfg_step_en = pwdata[0];
                    default:                     ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict beat with no verdict pending: status %0d", res.status);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    fail_count += check_field("status", 32'(want.status),
                                              32'(res.status));
                    fail_count += check_field("frame_length", 32'(want.frame_length),
                                              32'(res.frame_length));
                    fail_count += check_field("received_step", 32'(want.received_step),
                                              32'(res.received_step));
                    fail_count += check_field("computed_sum", 32'(want.computed_sum),
                                              32'(res.computed_sum));
                end
            end
            if (rx.valid && rx.ready)
            begin
                if (take_byte(rx.rx_byte, fresh))
                begin
                    verdict_q.push_back(fresh);
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the ASCII frame checker. After reset it sends a short list of
// hand-made frames and stray bytes, then runs several register settings, each
// with random frames, broken frames and noise bytes; both channels idle at
// random, but not in every fourth setting. The verdict checker beside the block reports the failure count.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RUN_LIMIT     = 600_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 65;
    localparam int PHASE_COUNT   = 10;

    typedef enum int {
        SUM_GOOD,
        SUM_WRONG_DIGIT,
        SUM_LOWER_CASE,
        SUM_ANY_BYTE
    } sum_fault_e;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [afc_pkg::APB_ADDR_W-1:0] paddr;
    logic [afc_pkg::APB_DATA_W-1:0] pwdata;
    logic [afc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int                             fail_count;
    int                             pending;
    int                             cycle_count;
    int                             sent_count;
    bit                             steady;
    logic [13:0]                    cur_step;
    logic [7:0]                     frame_bytes[$];

    afc_rx_if  rx_ch();
    afc_res_if res_ch();

    ascii_frame_checker i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_ch),
        .res     (res_ch)
    );

    afc_verdict_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .rx         (rx_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("ascii_frame_checker verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : verdict_sink
        int stall;
        forever
        begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = gap_len();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= 8'h30 && b <= 8'h39);
        return b;
    endfunction

    function automatic void build_frame(input int len, input int stepv, input bit step_bad,
                                        input sum_fault_e fault);
        int         place[4];
        int         at;
        logic [7:0] s;
        logic [3:0] cur;
        place = '{1000, 100, 10, 1};
        frame_bytes.delete();
        frame_bytes.push_back(afc_pkg::START_BYTE);
        frame_bytes.push_back(8'h30 + 8'(len / 10));
        frame_bytes.push_back(8'h30 + 8'(len % 10));
        for (int i = 3; i < len; i++)
        begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < 4; i++)
        begin
            if (4 + i < len - 3)
            begin
                frame_bytes[4 + i] = 8'h30 + 8'((stepv / place[i]) % 10);
            end
        end
        if (step_bad)
        begin
            at = $urandom_range(4, 7);
            if (at < len - 3)
            begin
                frame_bytes[at] = non_digit();
            end
        end
        s = '0;
        for (int i = 0; i <= len - 4; i++)
        begin
            s = s + frame_bytes[i];
        end
        frame_bytes[len - 3] = hex_char(s[7:4]);
        frame_bytes[len - 2] = hex_char(s[3:0]);
        at  = len - 3 + $urandom_range(0, 1);
        cur = (at == len - 3) ? s[7:4] : s[3:0];
        case (fault)
            SUM_WRONG_DIGIT: frame_bytes[at] = hex_char(cur ^ 4'($urandom_range(1, 15)));
            SUM_LOWER_CASE:
            begin
                if (frame_bytes[at] >= 8'h41 && frame_bytes[at] <= 8'h46)
                begin
                    frame_bytes[at] = frame_bytes[at] + 8'h20;
                end
                else
                begin
                    frame_bytes[at] = 8'h61 + 8'($urandom_range(0, 5));
                end
            end
            SUM_ANY_BYTE:    frame_bytes[at] = 8'($urandom_range(0, 255));
            default:         ;
        endcase
    endfunction

    function automatic void build_bad_length(input logic [7:0] tens, input logic [7:0] ones);
        frame_bytes.delete();
        frame_bytes.push_back(afc_pkg::START_BYTE);
        frame_bytes.push_back(tens);
        frame_bytes.push_back(ones);
        repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        sent_count++;
    endtask

    task automatic send_bytes(input int n);
        for (int i = 0; i < n && i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i]);
        end
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx,
                             input logic [afc_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(7, 14);
        end
        if (r < 95)
        begin
            return $urandom_range(15, 30);
        end
        if (r == 99)
        begin
            return 99;
        end
        return $urandom_range(31, 99);
    endfunction

    task automatic random_item();
        int         r;
        int         len;
        int         stepv;
        sum_fault_e fault;
        logic [7:0] b;
        r     = $urandom_range(0, 99);
        len   = pick_len();
        stepv = ($urandom_range(0, 9) < 6 && cur_step <= 14'd9999) ?
                int'(cur_step) : $urandom_range(0, 9999);
        fault = ($urandom_range(0, 5) == 0) ? sum_fault_e'($urandom_range(1, 3)) : SUM_GOOD;
        if (r < 65)
        begin
            build_frame(len, stepv, $urandom_range(0, 9) == 0, fault);
            send_bytes(frame_bytes.size());
        end
        else if (r < 75)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                build_bad_length(8'h30, 8'h30 + 8'($urandom_range(0, 6)));
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                build_bad_length(non_digit(), 8'($urandom_range(0, 255)));
            end
            else
            begin
                build_bad_length(8'h30 + 8'($urandom_range(0, 9)), non_digit());
            end
            send_bytes(frame_bytes.size());
        end
        else if (r < 87)
        begin
            repeat ($urandom_range(1, 3))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == afc_pkg::START_BYTE);
                send_byte(b);
            end
        end
        else
        begin
            build_frame(len, stepv, 1'b0, fault);
            send_bytes($urandom_range(1, len - 1));
        end
    endtask

    initial
    begin : stimulus
        logic [13:0] exp_step;
        logic        sum_en;
        logic        step_en;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        steady        <= 1'b0;
        cur_step       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        build_frame(7, 0, 1'b0, SUM_GOOD);
        send_bytes(frame_bytes.size());
        build_frame(8, 0, 1'b0, SUM_GOOD);
        send_bytes(frame_bytes.size());
        build_frame(11, 0, 1'b0, SUM_GOOD);
        send_bytes(frame_bytes.size());
        build_frame(11, 1234, 1'b0, SUM_GOOD);
        send_bytes(frame_bytes.size());
        build_frame(12, 0, 1'b1, SUM_GOOD);
        send_bytes(frame_bytes.size());
        build_frame(10, 0, 1'b0, SUM_WRONG_DIGIT);
        send_bytes(frame_bytes.size());
        build_frame(9, 0, 1'b0, SUM_LOWER_CASE);
        send_bytes(frame_bytes.size());
        build_frame(15, 9999, 1'b0, SUM_WRONG_DIGIT);
        send_bytes(frame_bytes.size());
        build_bad_length(8'h30, 8'h30);
        send_bytes(frame_bytes.size());
        build_bad_length(8'h30, 8'h36);
        send_bytes(frame_bytes.size());
        build_bad_length(non_digit(), 8'h39);
        send_bytes(frame_bytes.size());
        build_frame(99, 0, 1'b0, SUM_GOOD);
        send_bytes(frame_bytes.size());
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    exp_step = 14'd9999;
                    sum_en   = 1'b1;
                    step_en  = 1'b1;
                end
                1:
                begin
                    exp_step = 14'd0;
                    sum_en   = 1'b0;
                    step_en  = 1'b1;
                end
                2:
                begin
                    exp_step = 14'h3FFF;
                    sum_en   = 1'b1;
                    step_en  = 1'b0;
                end
                3:
                begin
                    exp_step = 14'd0;
                    sum_en   = 1'b0;
                    step_en  = 1'b0;
                end
                default:
                begin
                    exp_step = ($urandom_range(0, 7) == 0) ? 14'($urandom) :
                               14'($urandom_range(0, 9999));
                    sum_en   = $urandom_range(0, 3) != 0;
                    step_en  = $urandom_range(0, 3) != 0;
                end
            endcase
            cur_step = exp_step;
            apb_write(afc_pkg::REG_EXPECTED_STEP, {18'($urandom), exp_step});
            apb_write(afc_pkg::REG_CHECKSUM_CHECK, {31'($urandom), sum_en});
            apb_write(afc_pkg::REG_STEP_CHECK, {31'($urandom), step_en});
            steady     <= (phase % 4 == 3);
            sent_count  = 0;
            while (sent_count < PHASE_BYTES)
            begin
                random_item();
            end
            wait_idle();
        end

        @(negedge clk);
        if (fail_count == 0)
        begin
            $display("ascii_frame_checker verification clean");
        end
        else
        begin
            $display("ascii_frame_checker verification failed");
        end
        $finish;
    end

endmodule
